// ===== hdl/gasp_pkg.sv =====
`timescale 1ns / 1ps

package gasp_pkg;

  // Row table sizing
  localparam int MAX_ROWS = 32;
  localparam int ROW_AW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CNT_W    = $clog2(MAX_ROWS + 1);

  // Field widths
  localparam int DIM_W  = 13;
  localparam int POS_W  = 12;
  localparam int SLOT_W = 5;
  localparam int RH_W   = DIM_W + 1;   // h + h/10 can exceed 13 bits
  localparam int EXT_W  = DIM_W + 4;   // room for 10*h and 7*span

  // Height ratio window [0.7, 1.0] as 10*h >= 7*span
  localparam int RATIO_NUM = 10;
  localparam int RATIO_DEN = 7;

  // h/10 as (h * 6554) >> 16, exact for h below 16384
  localparam int DIV10_MUL   = 6554;
  localparam int DIV10_SHIFT = 16;
  localparam int DIV10_W     = DIM_W + 13;

  localparam logic [DIM_W-1:0] FIRST_TOP = DIM_W'(3);
  localparam logic [DIM_W-1:0] TEX_RESET = DIM_W'(128);

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT = 1'b1;

  typedef struct packed {
    logic [DIM_W-1:0] top;
    logic [DIM_W-1:0] span;
    logic [DIM_W-1:0] fill;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  typedef struct packed {
    logic              found;
    logic [ROW_AW-1:0] idx;
    row_t              row;
  } best_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } state_t;

endpackage

// ===== hdl/glyph_atlas_shelf_packer_core.sv =====
`timescale 1ns / 1ps

// Shelf packer for a glyph texture atlas.
// Input: raise start with in_req_width / in_req_height while busy is low;
// the beat is taken at that clock edge and busy goes high.
// Output: one result beat per request, on out_pos_x, out_pos_y, out_placed
// and out_row_slot, marked by out_valid for exactly one cycle. The receiver
// cannot stall; the beat must be captured in that cycle.
// Sequence: after the accepting edge the scan reads the open rows from
// the row table, which sits in one single-port-read RAM, one row per
// cycle; it then drains the last read, and the decide state does the
// read-modify-write for the chosen row and sets the registered out_valid.
// With no row open the scan is empty, and a zero height skips the scan.
// The next request can be taken in the cycle out_valid is high.
// Configuration: cfg_we / cfg_index / cfg_wdata write tex_width (index 0)
// and tex_height (index 1); write only while busy is low.
// Reset (rst_n low, synchronous): empty row table, next free top line 3,
// both texture dimensions 128. The RAM holds no reset and needs no clearing
// pass; only rows already opened are ever read.

module glyph_atlas_shelf_packer_core import gasp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [DIM_W-1:0]     in_req_width,
  input  logic [DIM_W-1:0]     in_req_height,
  output logic                 out_valid,
  output logic [POS_W-1:0]     out_pos_x,
  output logic [POS_W-1:0]     out_pos_y,
  output logic                 out_placed,
  output logic [SLOT_W-1:0]    out_row_slot,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_wdata
);

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     issue_idx_r, issue_idx_nxt;
  logic                 chk_vld_r, chk_vld_nxt;
  logic [ROW_AW-1:0]    chk_idx_r, chk_idx_nxt;
  logic [CNT_W-1:0]     row_count_r, row_count_nxt;
  logic [DIM_W-1:0]     nft_r, nft_nxt;
  logic [DIM_W-1:0]     tex_width_r, tex_height_r;
  logic [DIM_W-1:0]     req_w_r, req_h_r;
  logic [RH_W-1:0]      rh_r;
  logic                 h_zero_r;
  logic                 out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]     out_pos_x_r, out_pos_x_nxt;
  logic [POS_W-1:0]     out_pos_y_r, out_pos_y_nxt;
  logic                 out_placed_r, out_placed_nxt;
  logic [SLOT_W-1:0]    out_slot_r, out_slot_nxt;

  logic                 accept;
  logic                 scan_clear;
  logic [DIV10_W-1:0]   h_prod;
  logic [RH_W-1:0]      rh_in;
  logic [DIM_W+1:0]     new_bottom;
  logic                 new_fail;

  logic                 ram_we;
  logic [ROW_AW-1:0]    ram_waddr;
  row_t                 ram_wrow;
  logic                 ram_re;
  logic [ROW_AW-1:0]    ram_raddr;
  logic [ROW_W-1:0]     ram_rdata;
  row_t                 rd_row;
  best_t                best;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // New row height h + h/10, worked out when the request is taken
  assign h_prod = DIV10_W'(in_req_height) * DIV10_W'(DIV10_MUL);
  assign rh_in  = RH_W'(in_req_height) + RH_W'(h_prod >> DIV10_SHIFT);

  // Row table storage
  gasp_row_ram #(
    .DEPTH (MAX_ROWS),
    .WIDTH (ROW_W),
    .AW    (ROW_AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wrow),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_row = row_t'(ram_rdata);

  gasp_row_eval u_eval (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (scan_clear),
    .chk_vld   (chk_vld_r),
    .chk_idx   (chk_idx_r),
    .rd_row    (rd_row),
    .req_w     (req_w_r),
    .req_h     (req_h_r),
    .tex_width (tex_width_r),
    .best      (best)
  );

  // New-row checks: table full, atlas too short, too wide
  always_comb begin
    new_bottom = (DIM_W+2)'(nft_r) + (DIM_W+2)'(rh_r);
    new_fail   = (row_count_r == CNT_W'(MAX_ROWS))
              || (new_bottom >= (DIM_W+2)'(tex_height_r))
              || (req_w_r >= tex_width_r);
  end

  // Sequencer: scan rows, then read-modify-write the chosen row, open a new row or report a failure
  always_comb begin
    state_nxt      = state_r;
    issue_idx_nxt  = issue_idx_r;
    chk_vld_nxt    = 1'b0;
    chk_idx_nxt    = chk_idx_r;
    row_count_nxt  = row_count_r;
    nft_nxt        = nft_r;
    scan_clear     = 1'b0;
    ram_re         = 1'b0;
    ram_raddr      = issue_idx_r[ROW_AW-1:0];
    ram_we         = 1'b0;
    ram_waddr      = best.idx;
    ram_wrow       = best.row;
    out_valid_nxt  = 1'b0;
    out_pos_x_nxt  = out_pos_x_r;
    out_pos_y_nxt  = out_pos_y_r;
    out_placed_nxt = out_placed_r;
    out_slot_nxt   = out_slot_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          scan_clear    = 1'b1;
          issue_idx_nxt = '0;
          state_nxt     = (in_req_height == '0) ? ST_DECIDE : ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (issue_idx_r < row_count_r) begin
          ram_re        = 1'b1;
          chk_vld_nxt   = 1'b1;
          chk_idx_nxt   = issue_idx_r[ROW_AW-1:0];
          issue_idx_nxt = issue_idx_r + CNT_W'(1);
        end else if (!chk_vld_r) begin
          state_nxt = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        if (h_zero_r) begin
          out_pos_x_nxt  = '0;
          out_pos_y_nxt  = '0;
          out_placed_nxt = 1'b0;
          out_slot_nxt   = '0;
        end else if (best.found) begin
          ram_we         = 1'b1;
          ram_waddr      = best.idx;
          ram_wrow       = best.row;
          ram_wrow.fill  = best.row.fill + req_w_r;
          out_pos_x_nxt  = POS_W'(best.row.fill);
          out_pos_y_nxt  = POS_W'(best.row.top);
          out_placed_nxt = 1'b1;
          out_slot_nxt   = SLOT_W'(best.idx);
        end else if (new_fail) begin
          out_pos_x_nxt  = '0;
          out_pos_y_nxt  = '0;
          out_placed_nxt = 1'b0;
          out_slot_nxt   = '0;
        end else begin
          ram_we         = 1'b1;
          ram_waddr      = row_count_r[ROW_AW-1:0];
          ram_wrow.top   = nft_r;
          ram_wrow.span  = DIM_W'(rh_r);
          ram_wrow.fill  = req_w_r;
          row_count_nxt  = row_count_r + CNT_W'(1);
          nft_nxt        = DIM_W'(new_bottom);
          out_pos_x_nxt  = '0;
          out_pos_y_nxt  = POS_W'(nft_r);
          out_placed_nxt = 1'b1;
          out_slot_nxt   = SLOT_W'(row_count_r);
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      issue_idx_r <= '0;
      chk_vld_r   <= 1'b0;
      row_count_r <= '0;
      nft_r       <= FIRST_TOP;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      issue_idx_r <= issue_idx_nxt;
      chk_vld_r   <= chk_vld_nxt;
      row_count_r <= row_count_nxt;
      nft_r       <= nft_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_width_r  <= TEX_RESET;
      tex_height_r <= TEX_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TEX_WIDTH:  tex_width_r  <= cfg_wdata;
        REG_TEX_HEIGHT: tex_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    chk_idx_r    <= chk_idx_nxt;
    out_pos_x_r  <= out_pos_x_nxt;
    out_pos_y_r  <= out_pos_y_nxt;
    out_placed_r <= out_placed_nxt;
    out_slot_r   <= out_slot_nxt;
    if (accept) begin
      req_w_r  <= in_req_width;
      req_h_r  <= in_req_height;
      rh_r     <= rh_in;
      h_zero_r <= (in_req_height == '0);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_pos_x    = out_pos_x_r;
  assign out_pos_y    = out_pos_y_r;
  assign out_placed   = out_placed_r;
  assign out_row_slot = out_slot_r;

endmodule

// ===== hdl/gasp_row_ram.sv =====
`timescale 1ns / 1ps

module gasp_row_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 39,
  parameter int AW    = 5
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/gasp_row_eval.sv =====
`timescale 1ns / 1ps

module gasp_row_eval import gasp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clear,
  input  logic              chk_vld,
  input  logic [ROW_AW-1:0] chk_idx,
  input  row_t              rd_row,
  input  logic [DIM_W-1:0]  req_w,
  input  logic [DIM_W-1:0]  req_h,
  input  logic [DIM_W-1:0]  tex_width,
  output best_t             best
);

  best_t              best_r;
  best_t              best_nxt;
  logic [EXT_W-1:0]   h_scaled;
  logic [EXT_W-1:0]   span_scaled;
  logic [DIM_W:0]     fill_end;
  logic               fits_ratio;
  logic               fits_width;
  logic               beats_best;

  // Qualify the row read last cycle
  always_comb begin
    h_scaled    = EXT_W'(req_h) * EXT_W'(RATIO_NUM);
    span_scaled = EXT_W'(rd_row.span) * EXT_W'(RATIO_DEN);
    fill_end    = {1'b0, rd_row.fill} + {1'b0, req_w};
    fits_ratio  = (h_scaled >= span_scaled) && (req_h <= rd_row.span);
    fits_width  = fill_end <= {1'b0, tex_width};
    // smaller span wins; equal span lets the later row take over
    beats_best  = !best_r.found || (rd_row.span <= best_r.row.span);
  end

  // Best-so-far tracker
  always_comb begin
    best_nxt = best_r;
    if (clear) begin
      best_nxt.found = 1'b0;
    end else if (chk_vld && fits_ratio && fits_width && beats_best) begin
      best_nxt.found = 1'b1;
      best_nxt.idx   = chk_idx;
      best_nxt.row   = rd_row;
    end
  end

  // Only the found flag needs a reset
  always_ff @(posedge clk) begin
    best_r.idx <= best_nxt.idx;
    best_r.row <= best_nxt.row;
    if (!rst_n) begin
      best_r.found <= 1'b0;
    end else begin
      best_r.found <= best_nxt.found;
    end
  end

  assign best = best_r;

endmodule

// ===== hdl/gasp_checker.sv =====
`timescale 1ns / 1ps

module gasp_checker import gasp_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input logic [POS_W-1:0]  out_pos_x,
  input logic [POS_W-1:0]  out_pos_y,
  input logic              out_placed,
  input logic [SLOT_W-1:0] out_row_slot
);

  // An accepted beat always makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted beat did not raise busy");

  // A result beat only appears once the work is done
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result beat while busy");

  // Finishing a request always yields a result beat
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result beat");

  // Result strobes are single-cycle pulses
  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  // A failed placement reports a zero position and slot
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_placed |->
      (out_pos_x == '0) && (out_pos_y == '0) && (out_row_slot == '0))
    else $error("failed placement with nonzero position");

endmodule

bind glyph_atlas_shelf_packer_core gasp_checker u_gasp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .out_valid    (out_valid),
  .out_pos_x    (out_pos_x),
  .out_pos_y    (out_pos_y),
  .out_placed   (out_placed),
  .out_row_slot (out_row_slot)
);
